FILE: src/assert_macros.svh
// assertion helpers, clocked on clk_i and masked during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define MSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define MSB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/msb_pkg.sv
`default_nettype none

package msb_pkg;

  // screen geometry
  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned NUM_PAGES     = SCREEN_HEIGHT / 8;
  localparam int unsigned STORE_SIZE    = SCREEN_WIDTH * NUM_PAGES;
  localparam int unsigned MEM_AW        = $clog2(STORE_SIZE);

  // result buffer
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PW    = $clog2(OUT_DEPTH);

  // port field widths
  localparam int unsigned ADDR_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TDATA_W    = 40;

  typedef enum logic [1:0] {
    OP_SPRITE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_POS         = 3'd0,
    CFG_Y_POS         = 3'd1,
    CFG_SPRITE_WIDTH  = 3'd2,
    CFG_SPRITE_HEIGHT = 3'd3,
    CFG_MIRROR_ON     = 3'd4,
    CFG_USE_MASK      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    UOP_MERGE = 2'd0,
    UOP_READ  = 2'd1,
    UOP_WRITE = 2'd2,
    UOP_NOP   = 2'd3
  } uop_kind_e;

  // x_pos and y_pos are two's complement
  typedef struct packed {
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] sprite_width;
    logic [7:0] sprite_height;
    logic       mirror_on;
    logic       use_mask;
  } cfg_t;

  // one framebuffer access; bits doubles as host write data
  typedef struct packed {
    uop_kind_e         kind;
    logic              hit;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        bits;
    logic [7:0]        mask;
  } uop_t;

endpackage

`default_nettype wire

FILE: src/msb_frame_ram.sv
`default_nettype none

module msb_frame_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 8,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-first: a same-edge write is not seen
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/msb_seq.sv
`default_nettype none
`include "assert_macros.svh"

module msb_seq (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire msb_pkg::cfg_t            cfg_i,
  input  wire logic                     restart_i,
  input  wire logic                     s_tvalid_i,
  output logic                          s_tready_o,
  input  wire logic [1:0]               op_i,
  input  wire logic [7:0]               bitmap_i,
  input  wire logic [7:0]               mask_i,
  input  wire logic [msb_pkg::ADDR_W-1:0] address_i,
  input  wire logic [7:0]               wdata_i,
  output logic                          uop_valid_o,
  output msb_pkg::uop_t                 uop_o,
  input  wire logic                     uop_ready_i
);
  import msb_pkg::*;

  logic [7:0] cc_q, cc_d;
  logic [5:0] prc_q, prc_d;
  logic       phase_q, phase_d;

  logic [7:0]  w_eff;
  logic [7:0]  col_off;
  logic [9:0]  col;
  logic        col_ok;
  logic [7:0]  page_base;
  logic [7:0]  page_sel;
  logic        page_ok;
  logic [2:0]  off;
  logic [15:0] b16;
  logic [15:0] m16;
  logic [7:0]  mask_eff;
  logic        need_two;
  logic        last;
  logic        issue;
  logic [8:0]  cc_inc;
  logic [8:0]  h_sum;
  logic [5:0]  rows;
  logic [5:0]  prc_inc;

  // screen position of the current sprite byte
  always_comb begin
    w_eff     = (cfg_i.sprite_width == 8'd0) ? 8'd1 : cfg_i.sprite_width;
    col_off   = cfg_i.mirror_on ? (w_eff - 8'd1 - cc_q) : cc_q;
    col       = {{2{cfg_i.x_pos[7]}}, cfg_i.x_pos} + {2'b00, col_off};
    col_ok    = !col[9] && (32'(col) < SCREEN_WIDTH);
    page_base = {{3{cfg_i.y_pos[7]}}, cfg_i.y_pos[7:3]} + {2'b00, prc_q};
    page_sel  = phase_q ? (page_base + 8'd1) : page_base;
    page_ok   = !page_sel[7] && (32'(page_sel) < NUM_PAGES);
    off       = cfg_i.y_pos[2:0];
    mask_eff  = cfg_i.use_mask ? mask_i : 8'd0;
    b16       = {8'd0, bitmap_i} << off;
    m16       = {8'd0, mask_eff} << off;
  end

  // a sprite byte straddling two pages takes two accesses
  assign need_two    = (op_i == OP_SPRITE) && (off != 3'd0);
  assign last        = !need_two || phase_q;
  assign uop_valid_o = s_tvalid_i;
  assign s_tready_o  = uop_ready_i && last;
  assign issue       = uop_valid_o && uop_ready_i;

  always_comb begin
    uop_o      = '0;
    uop_o.kind = UOP_NOP;
    case (op_i)
      OP_SPRITE: begin
        uop_o.kind = UOP_MERGE;
        uop_o.hit  = col_ok && page_ok;
        uop_o.addr = MEM_AW'(32'(page_sel[6:0]) * SCREEN_WIDTH + 32'(col[8:0]));
        uop_o.bits = phase_q ? b16[15:8] : b16[7:0];
        uop_o.mask = phase_q ? m16[15:8] : m16[7:0];
      end
      OP_READ: begin
        uop_o.kind = UOP_READ;
        uop_o.hit  = 32'(address_i) < STORE_SIZE;
        uop_o.addr = MEM_AW'(address_i);
      end
      OP_WRITE: begin
        uop_o.kind = UOP_WRITE;
        uop_o.hit  = 32'(address_i) < STORE_SIZE;
        uop_o.addr = MEM_AW'(address_i);
        uop_o.bits = wdata_i;
      end
      default: begin
        uop_o.kind = UOP_NOP;
      end
    endcase
  end

  // column and page row walk
  always_comb begin
    cc_inc  = {1'b0, cc_q} + 9'd1;
    h_sum   = {1'b0, cfg_i.sprite_height} + 9'd7;
    rows    = (h_sum[8:3] == 6'd0) ? 6'd1 : h_sum[8:3];
    prc_inc = prc_q + 6'd1;
    cc_d    = cc_q;
    prc_d   = prc_q;
    phase_d = phase_q;
    if (issue) begin
      phase_d = need_two && !phase_q;
    end
    if (s_tvalid_i && s_tready_o && (op_i == OP_SPRITE)) begin
      if (cc_inc >= {1'b0, w_eff}) begin
        cc_d  = 8'd0;
        prc_d = (prc_inc >= rows) ? 6'd0 : prc_inc;
      end else begin
        cc_d = cc_inc[7:0];
      end
    end
    if (restart_i) begin
      cc_d  = 8'd0;
      prc_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= 8'd0;
      prc_q   <= 6'd0;
      phase_q <= 1'b0;
    end else begin
      cc_q    <= cc_d;
      prc_q   <= prc_d;
      phase_q <= phase_d;
    end
  end

  `MSB_ASSERT(a_phase_after_first, $rose(phase_q) |-> $past(issue && need_two), "second half without first")

endmodule

`default_nettype wire

FILE: src/msb_rmw.sv
`default_nettype none
`include "assert_macros.svh"

module msb_rmw (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          uop_valid_i,
  input  wire msb_pkg::uop_t uop_i,
  output logic               uop_ready_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output logic [7:0]         m_tdata_o
);
  import msb_pkg::*;

  logic              clearing_q, clearing_d;
  logic [MEM_AW-1:0] clr_addr_q, clr_addr_d;

  logic              s1_valid_q;
  uop_t              s1_uop_q;
  logic              byp_q;
  logic [7:0]        byp_data_q;

  logic              issue;
  logic              inflight;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        ram_rdata;
  logic [7:0]        rd;
  logic [7:0]        merged;
  logic              push;
  logic              pop;
  logic [7:0]        push_data;

  logic [7:0]        fifo_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr_q;
  logic [OUT_PW-1:0] rd_ptr_q;
  logic [OUT_PW:0]   cnt_q;

  // result slots are reserved at issue, so stage 1 never stalls
  assign inflight    = s1_valid_q && (s1_uop_q.kind == UOP_READ);
  assign uop_ready_o = !clearing_q && ((32'(cnt_q) + 32'(inflight)) < OUT_DEPTH);
  assign issue       = uop_valid_i && uop_ready_o;

  msb_frame_ram #(
    .DEPTH  (STORE_SIZE),
    .DATA_W (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (uop_i.addr),
    .rdata_o (ram_rdata)
  );

  // stage 1: modify and write back, or push a read result
  always_comb begin
    rd     = byp_q ? byp_data_q : ram_rdata;
    merged = (rd & ~s1_uop_q.mask) | s1_uop_q.bits;
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = s1_valid_q && s1_uop_q.hit &&
                  (s1_uop_q.kind inside {UOP_MERGE, UOP_WRITE});
      mem_waddr = s1_uop_q.addr;
      mem_wdata = (s1_uop_q.kind == UOP_WRITE) ? s1_uop_q.bits : merged;
    end
    push      = s1_valid_q && (s1_uop_q.kind == UOP_READ);
    push_data = s1_uop_q.hit ? rd : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_uop_q <= uop_i;
    end
    byp_data_q <= mem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      byp_q      <= issue && mem_we && (mem_waddr == uop_i.addr);
    end
  end

  // clearing pass after reset
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      if (clr_addr_q == MEM_AW'(STORE_SIZE - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + MEM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // result buffer
  assign m_tvalid_o = (cnt_q != '0);
  assign m_tdata_o  = fifo_q[rd_ptr_q];
  assign pop        = m_tvalid_o && m_tready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OUT_PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PW'(1);
      end
      cnt_q <= cnt_q + (OUT_PW + 1)'(push) - (OUT_PW + 1)'(pop);
    end
  end

  `MSB_ASSERT(a_no_access_in_clear, clearing_q |-> !s1_valid_q, "access during clearing pass")
  `MSB_ASSERT_NEVER(a_fifo_overflow, push && !pop && (32'(cnt_q) == OUT_DEPTH), "result overflow")
  `MSB_ASSERT(a_bypass_src, byp_q |-> $past(mem_we), "bypass without a write")

endmodule

`default_nettype wire

FILE: src/masked_sprite_blitter_core.sv
`default_nettype none

// Masked sprite blitter for a page-ordered monochrome framebuffer of 128 x 64
// pixels, kept in an on-chip 1024-byte store (byte = eight vertical pixels, bit 0
// on top, address = page * 128 + column). Sprite bytes (tuser = 0) arrive page
// row by page row, one column per beat; each is shifted by y_pos mod 8 and merged
// into one or two framebuffer bytes (clear under mask when use_mask is set, then
// OR). tuser = 1 reads a framebuffer byte and returns it on the master side;
// tuser = 2 writes one; tuser = 3 is dropped. Rate: every framebuffer access is
// a read, a modify and a write-back through a one-read / one-write memory, one
// access per cycle unless clearing or the result buffer has no room; a sprite
// byte takes one access when y_pos is a multiple of 8, else two (it touches two
// pages); host reads and writes take one. A four-deep result buffer keeps the
// input flowing while results wait. After reset the store is cleared and no beat
// is taken meanwhile (configuration writes still are). Writing a listed configuration
// index restarts the sprite column/page-row walk; write configuration only while
// the block is idle.

module masked_sprite_blitter_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [msb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [msb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input beats
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // bitmap_byte[7:0], mask_byte[15:8], address[25:16], write_data[33:26]
  input  wire logic [msb_pkg::TDATA_W-1:0]     s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [1:0]                      s_axis_tuser_i,
  // result beats
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // read_data[7:0]
  output logic [7:0]                           m_axis_tdata_o
);
  import msb_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic restart;

  logic [7:0]        bitmap_byte;
  logic [7:0]        mask_byte;
  logic [ADDR_W-1:0] address;
  logic [7:0]        write_data;

  logic uop_valid;
  logic uop_ready;
  uop_t uop;

  // unpack the input beat
  assign bitmap_byte = s_axis_tdata_i[7:0];
  assign mask_byte   = s_axis_tdata_i[15:8];
  assign address     = s_axis_tdata_i[25:16];
  assign write_data  = s_axis_tdata_i[33:26];

  // configuration registers; indexes past the list are ignored
  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_X_POS: begin
          cfg_d.x_pos = cfg_wdata_i;
          restart     = 1'b1;
        end
        CFG_Y_POS: begin
          cfg_d.y_pos = cfg_wdata_i;
          restart     = 1'b1;
        end
        CFG_SPRITE_WIDTH: begin
          cfg_d.sprite_width = cfg_wdata_i;
          restart            = 1'b1;
        end
        CFG_SPRITE_HEIGHT: begin
          cfg_d.sprite_height = cfg_wdata_i;
          restart             = 1'b1;
        end
        CFG_MIRROR_ON: begin
          cfg_d.mirror_on = cfg_wdata_i[0];
          restart         = 1'b1;
        end
        CFG_USE_MASK: begin
          cfg_d.use_mask = cfg_wdata_i[0];
          restart        = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_pos         <= 8'd0;
      cfg_q.y_pos         <= 8'd0;
      cfg_q.sprite_width  <= 8'd8;
      cfg_q.sprite_height <= 8'd8;
      cfg_q.mirror_on     <= 1'b0;
      cfg_q.use_mask      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // turns each beat into framebuffer accesses
  msb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .bitmap_i    (bitmap_byte),
    .mask_i      (mask_byte),
    .address_i   (address),
    .wdata_i     (write_data),
    .uop_valid_o (uop_valid),
    .uop_o       (uop),
    .uop_ready_i (uop_ready)
  );

  // read-modify-write pipeline around the frame store
  msb_rmw u_rmw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_valid_i (uop_valid),
    .uop_i       (uop),
    .uop_ready_o (uop_ready),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
